// ===== sv/box_mean_threshold_binarize_core_assert.svh =====
// Assertion macros for the box mean threshold binarizer.
`ifndef BOX_MEAN_THRESHOLD_BINARIZE_CORE_ASSERT_SVH
`define BOX_MEAN_THRESHOLD_BINARIZE_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define BMTB_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define BMTB_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BMTB_ASSERT_IMPL(name, ante, cons, msg)
`define BMTB_ASSERT_NEXT(name, ante, cons, msg)
`endif
`endif

// ===== sv/bmtb_pkg.sv =====
// Shared types and constants of the box mean threshold binarizer.
package bmtb_pkg;

  localparam int MAX_RADIUS = 7;
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;

  localparam int PIX_W      = 8;
  localparam int COORD_W    = 11;
  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int RADIUS_W   = 3;
  localparam int THRESH_W   = 8;
  localparam int SIZE_W     = 12;
  localparam int PIX_MAX    = 255;

  localparam int RADIUS_RST = 1;
  localparam int THRESH_RST = 128;
  localparam int WIDTH_RST  = 640;
  localparam int HEIGHT_RST = 480;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIUS = 2'd0,
    REG_THRESH = 2'd1,
    REG_WIDTH  = 2'd2,
    REG_HEIGHT = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_in;
    logic             frame_start;
  } in_word_t;

  typedef struct packed {
    logic               binary_out;
    logic [COORD_W-1:0] center_row;
    logic [COORD_W-1:0] center_col;
  } out_word_t;

  typedef struct packed {
    logic               emit;
    logic [COORD_W-1:0] center_row;
    logic [COORD_W-1:0] center_col;
  } tag_t;

endpackage

// ===== sv/bmtb_ram.sv =====
// Generic single-write, single-read RAM with registered read-first output.
module bmtb_ram #(
  parameter int Width = 8,
  parameter int Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/bmtb_linebuf.sv =====
// Line stores and the registered partial vertical sums of one column.
module bmtb_linebuf #(
  parameter int MaxRadius = bmtb_pkg::MAX_RADIUS,
  parameter int MaxWidth  = bmtb_pkg::MAX_WIDTH,
  localparam int NumLines  = 2 * MaxRadius,
  localparam int AddrW     = $clog2(MaxWidth),
  localparam int SlotW     = $clog2(NumLines),
  localparam int SpanW     = $clog2(NumLines + 1),
  localparam int NumTerms  = NumLines + 1,
  localparam int NumGroups = (NumTerms + 3) / 4,
  localparam int CsumW     = $clog2(NumTerms * bmtb_pkg::PIX_MAX + 1)
) (
  input  logic                       clk_i,
  input  logic                       rd_en_i,
  input  logic [AddrW-1:0]           addr_i,
  input  logic [SlotW-1:0]           wr_slot_i,
  input  logic [bmtb_pkg::PIX_W-1:0] wr_data_i,
  input  logic [SlotW-1:0]           slot_i,
  input  logic [SpanW-1:0]           span_i,
  input  logic [bmtb_pkg::PIX_W-1:0] pix_i,
  input  logic                       ld_i,
  output logic [CsumW-1:0]           grp_o [NumGroups]
);

  logic [bmtb_pkg::PIX_W-1:0] rdata [NumLines];
  logic [bmtb_pkg::PIX_W-1:0] term  [NumTerms];
  logic [CsumW-1:0]           grp_d [NumGroups];
  logic [CsumW-1:0]           grp_q [NumGroups];

  for (genvar j = 0; j < NumLines; j++) begin : g_line
    bmtb_ram #(
      .Width(bmtb_pkg::PIX_W),
      .Depth(MaxWidth)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (rd_en_i && (wr_slot_i == SlotW'(j))),
      .waddr_i(addr_i),
      .wdata_i(wr_data_i),
      .re_i   (rd_en_i),
      .raddr_i(addr_i),
      .rdata_o(rdata[j])
    );
  end

  always_comb begin
    logic [SpanW-1:0] lag;
    term[0] = pix_i;
    for (int j = 0; j < NumLines; j++) begin
      if (slot_i >= SlotW'(j)) begin
        lag = SpanW'(slot_i) - SpanW'(j);
      end else begin
        lag = SpanW'(slot_i) + SpanW'(NumLines) - SpanW'(j);
      end
      if (lag == '0) begin
        lag = SpanW'(NumLines);
      end
      term[j+1] = (lag <= span_i) ? rdata[j] : '0;
    end
  end

  always_comb begin
    for (int g = 0; g < NumGroups; g++) begin
      grp_d[g] = '0;
      for (int e = 0; e < 4; e++) begin
        if (g * 4 + e < NumTerms) begin
          grp_d[g] = grp_d[g] + CsumW'(term[g*4+e]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      grp_q <= grp_d;
    end
  end

  assign grp_o = grp_q;

endmodule

// ===== sv/bmtb_window.sv =====
// Column sum delay line and the registered partial window sums.
module bmtb_window #(
  parameter int MaxRadius = bmtb_pkg::MAX_RADIUS,
  localparam int Taps      = 2 * MaxRadius + 1,
  localparam int SpanW     = $clog2(2 * MaxRadius + 1),
  localparam int CsumW     = $clog2(Taps * bmtb_pkg::PIX_MAX + 1),
  localparam int WsumW     = $clog2(Taps * Taps * bmtb_pkg::PIX_MAX + 1),
  localparam int NumGroups = (Taps + 3) / 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             shift_i,
  input  logic [CsumW-1:0] csum_i,
  input  logic [SpanW-1:0] span_i,
  input  logic             ld_i,
  output logic [WsumW-1:0] grp_o [NumGroups]
);

  logic [CsumW-1:0] taps_q [Taps];
  logic [WsumW-1:0] grp_d  [NumGroups];
  logic [WsumW-1:0] grp_q  [NumGroups];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < Taps; k++) begin
        taps_q[k] <= '0;
      end
    end else if (shift_i) begin
      taps_q[0] <= csum_i;
      for (int k = 1; k < Taps; k++) begin
        taps_q[k] <= taps_q[k-1];
      end
    end
  end

  always_comb begin
    for (int g = 0; g < NumGroups; g++) begin
      grp_d[g] = '0;
      for (int e = 0; e < 4; e++) begin
        if (g * 4 + e < Taps) begin
          if (SpanW'(g * 4 + e) <= span_i) begin
            grp_d[g] = grp_d[g] + WsumW'(taps_q[g*4+e]);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      grp_q <= grp_d;
    end
  end

  assign grp_o = grp_q;

endmodule

// ===== sv/box_mean_threshold_binarize_core.sv =====
// Box mean threshold binarizer: counters, stage control and threshold compare.
// A result word is registered in each stage (v1_q to v5_q) and in the output register before it appears.
// Throughput: one pixel word per cycle while the output is not stalled, set by one read of every line RAM per pixel.
// The stages advance independently, so a waiting result does not block input bubbles.
// Reset clears counters, valid bits, delay line and config; line RAMs are not cleared.
module box_mean_threshold_binarize_core #(
  parameter int MaxRadius = bmtb_pkg::MAX_RADIUS,
  parameter int MaxWidth  = bmtb_pkg::MAX_WIDTH,
  parameter int MaxHeight = bmtb_pkg::MAX_HEIGHT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bmtb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bmtb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  input  bmtb_pkg::in_word_t              in_word_i,
  output logic                            in_stall_o,
  output logic                            out_valid_o,
  output bmtb_pkg::out_word_t             out_word_o,
  input  logic                            out_stall_i
);

  `include "box_mean_threshold_binarize_core_assert.svh"

  localparam int NumLines = 2 * MaxRadius;
  localparam int Side     = 2 * MaxRadius + 1;
  localparam int SlotW    = $clog2(NumLines);
  localparam int SpanW    = $clog2(NumLines + 1);
  localparam int RadW     = $clog2(MaxRadius + 1);
  localparam int ColW     = $clog2(MaxWidth + 1);
  localparam int RowW     = $clog2(MaxHeight + 1);
  localparam int AddrW    = $clog2(MaxWidth);
  localparam int CsumW    = $clog2(Side * bmtb_pkg::PIX_MAX + 1);
  localparam int WsumW    = $clog2(Side * Side * bmtb_pkg::PIX_MAX + 1);
  localparam int AreaW    = $clog2(Side * Side + 1);
  localparam int ProdW    = $clog2((bmtb_pkg::PIX_MAX + 1) * Side * Side + 1);
  localparam int CsGroups = (NumLines + 1 + 3) / 4;
  localparam int WsGroups = (Side + 3) / 4;

  localparam int RstRad  = (bmtb_pkg::RADIUS_RST > MaxRadius) ? MaxRadius : bmtb_pkg::RADIUS_RST;
  localparam int RstW    = (bmtb_pkg::WIDTH_RST > MaxWidth) ? MaxWidth : bmtb_pkg::WIDTH_RST;
  localparam int RstH    = (bmtb_pkg::HEIGHT_RST > MaxHeight) ? MaxHeight : bmtb_pkg::HEIGHT_RST;
  localparam int RstArea = (2 * RstRad + 1) * (2 * RstRad + 1);
  localparam int RstProd = (bmtb_pkg::THRESH_RST + 1) * RstArea;

  logic [bmtb_pkg::RADIUS_W-1:0] radius_q;
  logic [bmtb_pkg::THRESH_W-1:0] thresh_q;
  logic [bmtb_pkg::SIZE_W-1:0]   width_q;
  logic [bmtb_pkg::SIZE_W-1:0]   height_q;

  logic [RadW-1:0]  rad_d, rad_q;
  logic [SpanW-1:0] span_q;
  logic [AreaW-1:0] area_q;
  logic [ProdW-1:0] prod_q;
  logic [ColW-1:0]  wmax_d, wmax_q;
  logic [RowW-1:0]  hmax_d, hmax_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= bmtb_pkg::RADIUS_W'(bmtb_pkg::RADIUS_RST);
      thresh_q <= bmtb_pkg::THRESH_W'(bmtb_pkg::THRESH_RST);
      width_q  <= bmtb_pkg::SIZE_W'(bmtb_pkg::WIDTH_RST);
      height_q <= bmtb_pkg::SIZE_W'(bmtb_pkg::HEIGHT_RST);
    end else if (cfg_we_i) begin
      case (bmtb_pkg::reg_idx_e'(cfg_idx_i))
        bmtb_pkg::REG_RADIUS: radius_q <= cfg_data_i[bmtb_pkg::RADIUS_W-1:0];
        bmtb_pkg::REG_THRESH: thresh_q <= cfg_data_i[bmtb_pkg::THRESH_W-1:0];
        bmtb_pkg::REG_WIDTH:  width_q  <= cfg_data_i[bmtb_pkg::SIZE_W-1:0];
        bmtb_pkg::REG_HEIGHT: height_q <= cfg_data_i[bmtb_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    rad_d = (32'(radius_q) > MaxRadius) ? RadW'(MaxRadius) : RadW'(radius_q);
    if (width_q == '0) begin
      wmax_d = ColW'(1);
    end else if (32'(width_q) > MaxWidth) begin
      wmax_d = ColW'(MaxWidth);
    end else begin
      wmax_d = ColW'(width_q);
    end
    if (height_q == '0) begin
      hmax_d = RowW'(1);
    end else if (32'(height_q) > MaxHeight) begin
      hmax_d = RowW'(MaxHeight);
    end else begin
      hmax_d = RowW'(height_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rad_q  <= RadW'(RstRad);
      span_q <= SpanW'(2 * RstRad);
      area_q <= AreaW'(RstArea);
      prod_q <= ProdW'(RstProd);
      wmax_q <= ColW'(RstW);
      hmax_q <= RowW'(RstH);
    end else begin
      rad_q  <= rad_d;
      span_q <= SpanW'(32'(rad_d) * 2);
      area_q <= AreaW'((32'(rad_q) * 2 + 1) * (32'(rad_q) * 2 + 1));
      prod_q <= ProdW'((32'(thresh_q) + 1) * 32'(area_q));
      wmax_q <= wmax_d;
      hmax_q <= hmax_d;
    end
  end

  logic ld1, ld2, ld3, ld4, ld5, ldo;
  logic v1_q, v2_q, v3_q, v4_q, v5_q, out_valid_q;
  logic accept;

  bmtb_pkg::tag_t             tag1_q, tag2_q, tag3_q, tag4_q, tag5_q;
  logic [SlotW-1:0]           slot1_q;
  logic [bmtb_pkg::PIX_W-1:0] pix1_q;
  logic [WsumW-1:0]           wsum_d, wsum5_q;
  logic [CsumW-1:0]           csum_d;
  logic [CsumW-1:0]           cs_grp [CsGroups];
  logic [WsumW-1:0]           ws_grp [WsGroups];
  bmtb_pkg::out_word_t        out_word_q;

  assign ldo = !out_valid_q || !out_stall_i;
  assign ld5 = !v5_q || ldo;
  assign ld4 = !v4_q || ld5;
  assign ld3 = !v3_q || ld4;
  assign ld2 = !v2_q || ld3;
  assign ld1 = !v1_q || ld2;
  assign accept = in_valid_i && ld1;
  assign in_stall_o = !ld1;

  logic [ColW-1:0]  col_q, col_n;
  logic [RowW-1:0]  row_q, row_n;
  logic [SlotW-1:0] slot_q, slot_n;
  bmtb_pkg::tag_t   tag_d;

  always_comb begin
    col_n  = col_q;
    row_n  = row_q;
    slot_n = slot_q;
    if (in_word_i.frame_start) begin
      col_n  = '0;
      row_n  = '0;
      slot_n = '0;
    end else if (col_q >= wmax_q) begin
      col_n  = '0;
      row_n  = row_q + RowW'(1);
      slot_n = (slot_q == SlotW'(NumLines - 1)) ? '0 : slot_q + SlotW'(1);
    end
    if (row_n >= hmax_q) begin
      row_n  = '0;
      slot_n = '0;
    end
    tag_d.emit = (32'(row_n) >= 32'(span_q)) && (32'(col_n) >= 32'(span_q));
    tag_d.center_row = bmtb_pkg::COORD_W'(32'(row_n) - 32'(rad_q));
    tag_d.center_col = bmtb_pkg::COORD_W'(32'(col_n) - 32'(rad_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      slot_q <= '0;
    end else if (accept) begin
      col_q  <= col_n + ColW'(1);
      row_q  <= row_n;
      slot_q <= slot_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ld1) begin
        v1_q <= in_valid_i;
      end
      if (ld2) begin
        v2_q <= v1_q;
      end
      if (ld3) begin
        v3_q <= v2_q;
      end
      if (ld4) begin
        v4_q <= v3_q;
      end
      if (ld5) begin
        v5_q <= v4_q;
      end
      if (ldo) begin
        out_valid_q <= v5_q && tag5_q.emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld1) begin
      tag1_q  <= tag_d;
      slot1_q <= slot_n;
      pix1_q  <= in_word_i.pixel_in;
    end
    if (ld2) begin
      tag2_q <= tag1_q;
    end
    if (ld3) begin
      tag3_q <= tag2_q;
    end
    if (ld4) begin
      tag4_q <= tag3_q;
    end
    if (ld5) begin
      tag5_q  <= tag4_q;
      wsum5_q <= wsum_d;
    end
    if (ldo) begin
      out_word_q.binary_out <= 32'(wsum5_q) >= 32'(prod_q);
      out_word_q.center_row <= tag5_q.center_row;
      out_word_q.center_col <= tag5_q.center_col;
    end
  end

  bmtb_linebuf #(
    .MaxRadius(MaxRadius),
    .MaxWidth (MaxWidth)
  ) u_linebuf (
    .clk_i    (clk_i),
    .rd_en_i  (accept),
    .addr_i   (col_n[AddrW-1:0]),
    .wr_slot_i(slot_n),
    .wr_data_i(in_word_i.pixel_in),
    .slot_i   (slot1_q),
    .span_i   (span_q),
    .pix_i    (pix1_q),
    .ld_i     (ld2),
    .grp_o    (cs_grp)
  );

  always_comb begin
    csum_d = '0;
    for (int g = 0; g < CsGroups; g++) begin
      csum_d = csum_d + cs_grp[g];
    end
  end

  bmtb_window #(
    .MaxRadius(MaxRadius)
  ) u_window (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .shift_i(ld3 && v2_q),
    .csum_i (csum_d),
    .span_i (span_q),
    .ld_i   (ld4),
    .grp_o  (ws_grp)
  );

  always_comb begin
    wsum_d = '0;
    for (int g = 0; g < WsGroups; g++) begin
      wsum_d = wsum_d + ws_grp[g];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  `BMTB_ASSERT_NEXT(a_col_advances, accept, col_q != '0, "column counter did not advance")
  `BMTB_ASSERT_IMPL(a_slot_range, 1'b1, 32'(slot_q) < NumLines, "line slot out of range")
  `BMTB_ASSERT_IMPL(a_stall_full, in_stall_o, out_valid_o && out_stall_i, "stall without full pipe")
  `BMTB_ASSERT_NEXT(a_border_silent, ldo && v5_q && !tag5_q.emit, !out_valid_o, "border word emitted")

endmodule

// ===== bench/tb_box_mean_threshold_binarize_core.sv =====
// Self-checking testbench for the box mean threshold binarizer core.
module tb_box_mean_threshold_binarize_core;

  localparam int NUM_LINES    = 2 * bmtb_pkg::MAX_RADIUS;
  localparam int TAPS         = 2 * bmtb_pkg::MAX_RADIUS + 1;
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int RANDOM_ITEMS = 1350;
  localparam int LONG_ROW     = 64;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            cfg_we_i = 1'b0;
  logic [bmtb_pkg::CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [bmtb_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                            in_valid_i = 1'b0;
  bmtb_pkg::in_word_t              in_word_i = '0;
  logic                            in_stall_o;
  logic                            out_valid_o;
  bmtb_pkg::out_word_t             out_word_o;
  logic                            out_stall_i = 1'b0;

  box_mean_threshold_binarize_core u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i), .in_word_i(in_word_i), .in_stall_o(in_stall_o),
    .out_valid_o(out_valid_o), .out_word_o(out_word_o), .out_stall_i(out_stall_i)
  );

  always #6 clk_i = ~clk_i;

  // Binarizer state as the predictor sees it.
  logic [bmtb_pkg::RADIUS_W-1:0] radius_reg;
  logic [bmtb_pkg::THRESH_W-1:0] thresh_reg;
  logic [bmtb_pkg::SIZE_W-1:0]   width_reg;
  logic [bmtb_pkg::SIZE_W-1:0]   height_reg;
  logic [bmtb_pkg::PIX_W-1:0]    line_mem [NUM_LINES][bmtb_pkg::MAX_WIDTH];
  int                            col_delay [TAPS];
  int                            row_pos;
  int                            col_pos;

  bmtb_pkg::out_word_t expected_bits_q [$];
  int                  fail_count = 0;
  int                  cycle_count = 0;
  int                  pixels_sent = 0;
  int                  idle_pct = 0;
  int                  stall_pct = 0;

  function automatic int clamp_size(input int v, input int hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic bit binarize_pixel(input logic [bmtb_pkg::PIX_W-1:0] pix, input bit fs,
                                        output bmtb_pkg::out_word_t res);
    int w, h, r, span, csum, wsum, area;
    w = clamp_size(int'(width_reg), bmtb_pkg::MAX_WIDTH);
    h = clamp_size(int'(height_reg), bmtb_pkg::MAX_HEIGHT);
    r = int'(radius_reg);
    span = 2 * r;
    res = '0;
    if (fs) begin
      row_pos = 0;
      col_pos = 0;
    end else if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    csum = int'(pix);
    for (int k = 1; k <= span; k++)
      csum += int'(line_mem[(row_pos + NUM_LINES - k) % NUM_LINES][col_pos]);
    line_mem[row_pos % NUM_LINES][col_pos] = pix;
    for (int k = TAPS - 1; k > 0; k--) col_delay[k] = col_delay[k-1];
    col_delay[0] = csum & 12'hFFF;
    binarize_pixel = 1'b0;
    if (row_pos >= span && col_pos >= span) begin
      wsum = 0;
      for (int k = 0; k <= span; k++) wsum += col_delay[k];
      area = (span + 1) * (span + 1);
      res.binary_out = (wsum >= (int'(thresh_reg) + 1) * area);
      res.center_row = bmtb_pkg::COORD_W'(row_pos - r);
      res.center_col = bmtb_pkg::COORD_W'(col_pos - r);
      binarize_pixel = 1'b1;
    end
    col_pos++;
  endfunction

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(negedge clk_i) out_stall_i <= ($urandom_range(99) < stall_pct);

  always @(posedge clk_i) begin
    bmtb_pkg::out_word_t exp_w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_bits_q.size() == 0) begin
        $error("unexpected result word row=%0d col=%0d",
               out_word_o.center_row, out_word_o.center_col);
        fail_count++;
      end else begin
        exp_w = expected_bits_q.pop_front();
        if (out_word_o.binary_out !== exp_w.binary_out) begin
          $error("binary_out expected %0d actual %0d", exp_w.binary_out,
                 out_word_o.binary_out);
          fail_count++;
        end
        if (out_word_o.center_row !== exp_w.center_row) begin
          $error("center_row expected %0d actual %0d", exp_w.center_row,
                 out_word_o.center_row);
          fail_count++;
        end
        if (out_word_o.center_col !== exp_w.center_col) begin
          $error("center_col expected %0d actual %0d", exp_w.center_col,
                 out_word_o.center_col);
          fail_count++;
        end
      end
    end
  end

  task automatic send_pixel(input logic [bmtb_pkg::PIX_W-1:0] pix, input bit fs);
    bmtb_pkg::out_word_t res;
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_word_i <= '{pixel_in: pix, frame_start: fs};
    do @(posedge clk_i); while (in_stall_o);
    pixels_sent++;
    if (binarize_pixel(pix, fs, res)) expected_bits_q = {expected_bits_q, res};
  endtask

  task automatic drain;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_bits_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input bmtb_pkg::reg_idx_e idx, input int value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= bmtb_pkg::CFG_DATA_W'(value);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      bmtb_pkg::REG_RADIUS: radius_reg = bmtb_pkg::RADIUS_W'(value);
      bmtb_pkg::REG_THRESH: thresh_reg = bmtb_pkg::THRESH_W'(value);
      bmtb_pkg::REG_WIDTH:  width_reg  = bmtb_pkg::SIZE_W'(value);
      bmtb_pkg::REG_HEIGHT: height_reg = bmtb_pkg::SIZE_W'(value);
      default: ;
    endcase
  endtask

  task automatic set_geometry(input int r, input int t, input int w, input int h);
    write_reg(bmtb_pkg::REG_RADIUS, r);
    write_reg(bmtb_pkg::REG_THRESH, t);
    write_reg(bmtb_pkg::REG_WIDTH, w);
    write_reg(bmtb_pkg::REG_HEIGHT, h);
  endtask

  // Sends a frame starting with a frame start; pixels drawn from [lo, hi].
  task automatic send_frame(input int count, input int lo, input int hi);
    for (int i = 0; i < count; i++)
      send_pixel(bmtb_pkg::PIX_W'($urandom_range(hi, lo)), i == 0);
  endtask

  task automatic test_reset_values;
    send_pixel(8'd0, 1'b1);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd170, 1'b0);
    drain();
  endtask

  task automatic test_threshold_edges;
    set_geometry(0, 0, 4, 1);
    send_pixel(8'd0, 1'b1);
    send_pixel(8'd1, 1'b0);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd85, 1'b0);
    drain();
    write_reg(bmtb_pkg::REG_THRESH, 255);
    send_frame(4, 255, 255);
    drain();
    set_geometry(1, 100, 3, 3);
    send_frame(9, 101, 101);
    send_frame(9, 100, 100);
    drain();
  endtask

  task automatic test_size_extremes;
    set_geometry(0, 128, 0, 0);
    send_frame(3, 0, 255);
    drain();
    set_geometry(0, 127, 4095, 4095);
    send_frame(LONG_ROW, 0, 255);
    drain();
    set_geometry(7, 128, 15, 15);
    send_frame(15 * 15, 0, 255);
    drain();
  endtask

  task automatic test_random_frames;
    int r, span, w, h, t, lo, hi, count, mode;
    mode = 0;
    while (pixels_sent < RANDOM_ITEMS) begin
      case (mode % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 50; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 50; end
        default: begin idle_pct = 22; stall_pct = 22; end
      endcase
      mode++;
      r = ($urandom_range(3) == 0) ? $urandom_range(7) : $urandom_range(2);
      span = 2 * r;
      w = ($urandom_range(9) == 0) ? $urandom_range(span + 1, 1)
                                   : $urandom_range(span + 8, span + 1);
      h = $urandom_range(span + 3, span + 1);
      t = $urandom_range(255);
      set_geometry(r, t, w, h);
      lo = (t > 20) ? t - 20 : 0;
      hi = (t < 235) ? t + 20 : 255;
      count = w * h;
      if ($urandom_range(4) == 0) count = $urandom_range(count, 1);
      for (int i = 0; i < count; i++) begin
        if ($urandom_range(7) == 0)
          send_pixel(bmtb_pkg::PIX_W'($urandom_range(255)), i == 0);
        else
          send_pixel(bmtb_pkg::PIX_W'($urandom_range(hi, lo)), i == 0);
      end
      if ($urandom_range(3) == 0) begin
        // Restart the frame, then run a whole frame plus up to w - 1 pixels of the next one.
        count = $urandom_range(w - 1, 0);
        send_frame(w * h + count, lo, hi);
      end
      drain();
    end
    idle_pct = 0;
    stall_pct = 0;
  endtask

  initial begin
    radius_reg = bmtb_pkg::RADIUS_W'(bmtb_pkg::RADIUS_RST);
    thresh_reg = bmtb_pkg::THRESH_W'(bmtb_pkg::THRESH_RST);
    width_reg  = bmtb_pkg::SIZE_W'(bmtb_pkg::WIDTH_RST);
    height_reg = bmtb_pkg::SIZE_W'(bmtb_pkg::HEIGHT_RST);
    row_pos = 0;
    col_pos = 0;
    for (int k = 0; k < TAPS; k++) col_delay[k] = 0;
    for (int l = 0; l < NUM_LINES; l++)
      for (int c = 0; c < bmtb_pkg::MAX_WIDTH; c++) line_mem[l][c] = '0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_values();
    test_threshold_edges();
    test_size_extremes();
    test_random_frames();
    drain();
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== box_mean_threshold_binarize_core.f =====
+incdir+sv
sv/bmtb_pkg.sv
sv/bmtb_ram.sv
sv/bmtb_linebuf.sv
sv/bmtb_window.sv
sv/box_mean_threshold_binarize_core.sv
bench/tb_box_mean_threshold_binarize_core.sv
